// ===== hw/rtl/rhst_pkg.sv =====
`default_nettype none

package rhst_pkg;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture a new address and start a count
      logic scan;    // read the next table entry
      logic commit;  // write the address into the ring and settle the verdict
      logic finish;  // move the verdict into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;     // every filled entry has been read
      logic trigger_zero;  // the trigger register holds zero
      logic rsp_free;      // the output register can take a word this cycle
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/recent_host_scan_trigger_unit.sv =====
`default_nettype none

// Channel   Ports                                   Moves
// request   req_valid, req_ready, req_host_address  one source address per word
// response  rsp_valid, rsp_ready, rsp_scan_detected one verdict per request word
// csr       csr_write_enable, csr_write_data        trigger count, no wait
//
// A new request word is accepted only once the last one has been compared
// with the fill table entries written so far (fill is at most TABLE_DEPTH)
// and its result loaded; the single read port of the host table is walked one
// entry per cycle. With a zero trigger the scan and the ring write are skipped.
// Reset clears the trigger, the ring pointer and the fill count; the table
// itself is never cleared, since the fill count marks its valid entries.
// A stalled response holds in the output register; the block goes on to
// accept the next request word and stops only before loading the next result.

module recent_host_scan_trigger_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_host_address,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_scan_detected,

   input  wire logic        csr_write_enable,
   input  wire logic [7:0]  csr_write_data
);

   rhst_pkg::cmd_type    cmd;
   rhst_pkg::status_type status;

   // The controller sequences each word through scan, compare, ring write
   // and result hand-off.
   rhst_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the table, the hit counter, the trigger register
   // and the output register.
   rhst_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_host_address  (req_host_address),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_scan_detected (rsp_scan_detected)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/rhst_controller.sv =====
`default_nettype none

module rhst_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire rhst_pkg::status_type status,
   output rhst_pkg::cmd_type       cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_COMMIT = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // A zero trigger reports at once and leaves the table alone.
               state_in = status.trigger_zero ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_DRAIN: begin
            // No read is compared here; the last one was compared in the scan state.
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rhst_datapath.sv =====
`default_nettype none

module rhst_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [7:0]         csr_write_data,
   input  wire logic [31:0]        req_host_address,
   input  wire rhst_pkg::cmd_type  cmd,
   output rhst_pkg::status_type    status,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic                    rsp_scan_detected
);

   localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FW = $clog2(TABLE_DEPTH + 1);
   localparam int HW = $clog2(TABLE_DEPTH + 2);
   localparam int CW = (HW > 8) ? HW : 8;

   // Ring of recent addresses. Entries are written in ring order from slot
   // zero after reset, so slot i holds a valid address exactly when i is
   // below the fill count.
   logic [31:0]   host_table_ff [TABLE_DEPTH];

   logic [7:0]    trigger_ff, trigger_in;
   logic [PW-1:0] wptr_ff, wptr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          rd_pending_ff, rd_pending_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [31:0]   addr_ff;
   logic [FW-1:0] idx_ff;
   logic [HW-1:0] hits_ff;
   logic [31:0]   rd_data_ff;
   logic          det_ff;
   logic          rsp_det_ff;

   logic          hit;
   logic          verdict;

   assign hit     = rd_pending_ff && (rd_data_ff == addr_ff);
   assign verdict = (CW'(hits_ff) >= CW'(trigger_ff)) ||
                    (CW'(trigger_ff) > CW'(TABLE_DEPTH));

   assign status.scan_done    = (idx_ff == fill_ff);
   assign status.trigger_zero = (trigger_ff == 8'd0);
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scan_detected = rsp_det_ff;

   always_comb begin
      trigger_in    = csr_write_enable ? csr_write_data : trigger_ff;
      rd_pending_in = cmd.scan;
      wptr_in       = wptr_ff;
      fill_in       = fill_ff;
      if (cmd.commit) begin
         wptr_in = (wptr_ff == PW'(TABLE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         if (fill_ff != FW'(TABLE_DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ff    <= 8'd0;
         wptr_ff       <= '0;
         fill_ff       <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         trigger_ff    <= trigger_in;
         wptr_ff       <= wptr_in;
         fill_ff       <= fill_in;
         rd_pending_ff <= rd_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff <= req_host_address;
         idx_ff  <= '0;
         hits_ff <= HW'(1);
         det_ff  <= (trigger_ff == 8'd0);
      end else begin
         if (cmd.scan) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (hit) begin
            hits_ff <= hits_ff + 1'b1;
         end
         if (cmd.commit) begin
            det_ff <= verdict;
         end
      end
      if (cmd.finish) begin
         rsp_det_ff <= det_ff;
      end
   end

   // Table memory: one read and one write port, read data registered.
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         rd_data_ff <= host_table_ff[idx_ff[PW-1:0]];
      end
      if (cmd.commit) begin
         host_table_ff[wptr_ff] <= addr_ff;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rhst_checker.sv =====
`default_nettype none

module rhst_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_scan_detected
);

   // A waiting response word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scan_detected))
      else $error("response word changed while stalled");

   // One word at a time: after an accept the block is busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on two cycles in a row");

   // Reset leaves the block ready with no response pending.
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind recent_host_scan_trigger_unit rhst_checker u_chk (.*);

`default_nettype wire
